@@ hw/rtl/issr_pkg.sv @@
// Package for the interval-search square root core.
// Holds the fixed-point format, the subdivision count and the divide-by-ten constants.
// No dependencies.
package issr_pkg;

    // Fixed-point format of the value, the interval ends and the result
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int ROOT_W    = 25;
    localparam int TOL_W     = 16;
    localparam int TARGET_W  = VALUE_W + FRAC_BITS;
    localparam int PROD_W    = 2 * VALUE_W;

    localparam logic [VALUE_W-1:0] ONE = VALUE_W'(1) << FRAC_BITS;

    // Steps per level and the width of the step counter
    localparam int SUBDIVISIONS = 10;
    localparam int K_W          = $clog2(SUBDIVISIONS + 1);

    // floor(w / 10) == (w * RECIP_MAGIC) >> RECIP_SHIFT for every 32-bit w
    localparam logic [VALUE_W-1:0] RECIP_MAGIC = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam int                 STEP_W      = PROD_W - RECIP_SHIFT;

endpackage

@@ hw/rtl/interval_search_square_root_core.sv @@
// Interval-search square root core: unsigned Q16.16 in, Q16.16 root out.
// Depends on issr_pkg.
//
// o_value_stall stays high until the search for a value has finished.
// Every level of the search has a width check state, a divide-by-ten state
// (a multiply by reciprocal) and a square state and a compare state per step
// boundary tested, up to nine boundaries, since the last boundary is taken
// without a test. The widest start interval needs up to nine levels, and
// values below one need at most four. A single shared 32x32 multiplier
// serves both the divide-by-ten and the squares. The result sits in an
// output register, so a new value is taken while the previous root waits;
// the search only holds at its end if that register is still full.
// The tolerance register may be written at any time the core is idle.
module interval_search_square_root_core
    import issr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input value channel
    input  logic              i_value_valid,
    output logic              o_value_stall,
    input  logic [VALUE_W-1:0] i_value,
    // result channel
    output logic              o_root_valid,
    input  logic              i_root_stall,
    output logic [ROOT_W-1:0] o_root,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TOL_W-1:0]  i_cfg_tolerance
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RECIP,
        S_SQ,
        S_CMP
    } t_state;

    t_state                r_state,   n_state;
    logic [TOL_W-1:0]      r_tol,     n_tol;
    logic [VALUE_W-1:0]    r_lo,      n_lo;
    logic [VALUE_W-1:0]    r_hi,      n_hi;
    logic [TARGET_W-1:0]   r_target,  n_target;
    logic [VALUE_W-1:0]    r_prev,    n_prev;
    logic [VALUE_W-1:0]    r_b,       n_b;
    logic [VALUE_W-1:0]    r_q,       n_q;
    logic [3:0]            r_rem,     n_rem;
    logic [STEP_W-1:0]     r_step,    n_step;
    logic [3:0]            r_steprem, n_steprem;
    logic [K_W-1:0]        r_k,       n_k;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_root_valid, n_root_valid;
    logic [ROOT_W-1:0]     r_root,    n_root;

    logic                  value_beat;
    logic                  out_free;
    logic [VALUE_W-1:0]    width;
    logic                  search_done;
    logic [VALUE_W:0]      mid_sum;
    logic [VALUE_W-1:0]    mul_a;
    logic [VALUE_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [STEP_W-1:0]     step_w;
    logic [VALUE_W-1:0]    step_x10;
    logic [VALUE_W-1:0]    steprem_w;
    logic [4:0]            rem_sum;
    logic                  rem_carry;
    logic [VALUE_W-1:0]    q_next;
    logic [3:0]            rem_next;
    logic [K_W-1:0]        k_next;
    logic                  hit;

    assign value_beat    = i_value_valid && !o_value_stall;
    assign o_value_stall = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_root_valid  = r_root_valid;
    assign o_root        = r_root;
    assign out_free      = !r_root_valid || !i_root_stall;

    // Interval width and stop test
    assign width       = r_hi - r_lo;
    assign search_done = (width <= VALUE_W'(r_tol)) || (width < VALUE_W'(SUBDIVISIONS));
    assign mid_sum     = {1'b0, r_lo} + {1'b0, r_hi};

    // Shared multiplier: reciprocal of the width, or square of a boundary
    assign mul_a = (r_state == S_CHECK) ? width       : r_b;
    assign mul_b = (r_state == S_CHECK) ? RECIP_MAGIC : r_b;
    assign mul_p = mul_a * mul_b;

    // Whole step and leftover tenths of the width
    assign step_w    = r_prod[PROD_W-1:RECIP_SHIFT];
    assign step_x10  = {step_w, 3'b000} + {2'b00, step_w, 1'b0};
    assign steprem_w = width - step_x10;

    // Next boundary offset: floor(width * (k+1) / 10) built up step by step
    assign rem_sum   = {1'b0, r_rem} + {1'b0, r_steprem};
    assign rem_carry = (rem_sum >= 5'(SUBDIVISIONS));
    assign rem_next  = rem_carry ? 4'(rem_sum - 5'(SUBDIVISIONS)) : rem_sum[3:0];
    assign q_next    = r_q + VALUE_W'(r_step) + VALUE_W'(rem_carry);
    assign k_next    = r_k + K_W'(1);

    // Square of the boundary at or above value << FRAC_BITS
    assign hit = (r_prod >= PROD_W'(r_target));

    // Sequencer next-state logic
    always_comb begin
        n_state      = r_state;
        n_tol        = r_tol;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_target     = r_target;
        n_prev       = r_prev;
        n_b          = r_b;
        n_q          = r_q;
        n_rem        = r_rem;
        n_step       = r_step;
        n_steprem    = r_steprem;
        n_k          = r_k;
        n_root       = r_root;
        n_root_valid = r_root_valid && i_root_stall;

        if (i_cfg_valid && o_cfg_ready) begin
            n_tol = i_cfg_tolerance;
        end

        case (r_state)
            S_IDLE: begin
                if (value_beat) begin
                    n_lo     = '0;
                    n_hi     = (i_value > ONE) ? i_value : ONE;
                    n_target = {i_value, FRAC_BITS'(0)};
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (search_done) begin
                    if (out_free) begin
                        n_root       = mid_sum[ROOT_W:1];
                        n_root_valid = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_RECIP;
                end
            end
            S_RECIP: begin
                // first boundary: lo + floor(width / 10)
                n_step    = step_w;
                n_steprem = steprem_w[3:0];
                n_q       = VALUE_W'(step_w);
                n_rem     = steprem_w[3:0];
                n_k       = K_W'(1);
                n_prev    = r_lo;
                n_b       = r_lo + VALUE_W'(step_w);
                n_state   = S_SQ;
            end
            S_SQ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_lo    = r_prev;
                    n_hi    = r_b;
                    n_state = S_CHECK;
                end else if (k_next == K_W'(SUBDIVISIONS)) begin
                    // last step ends on hi and always brackets the root
                    n_lo    = r_b;
                    n_state = S_CHECK;
                end else begin
                    n_prev  = r_b;
                    n_b     = r_lo + q_next;
                    n_q     = q_next;
                    n_rem   = rem_next;
                    n_k     = k_next;
                    n_state = S_SQ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tol        <= TOL_W'(7);
            r_root_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tol        <= n_tol;
            r_root_valid <= n_root_valid;
        end
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_target  <= n_target;
        r_prev    <= n_prev;
        r_b       <= n_b;
        r_q       <= n_q;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_steprem <= n_steprem;
        r_k       <= n_k;
        r_prod    <= mul_p;
        r_root    <= n_root;
    end

    // Checks on the search
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        value_beat |=> o_value_stall)
        else $error("core took a value without going busy");

    a_interval_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK || r_state == S_RECIP) |-> (r_lo <= r_hi))
        else $error("search interval inverted");

    a_boundary_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ || r_state == S_CMP) |-> (r_prev < r_b && r_b <= r_hi))
        else $error("step boundary outside the interval");

    a_root_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_root_valid && i_root_stall) |=> (o_root_valid && $stable(o_root)))
        else $error("stalled root beat changed");

endmodule
